@@ src/kdrb_pkg.sv @@
// Shared types and constants for the key debounce / auto-repeat bank.
// Holds phase, event and mode codes, register indices and reset values.
// No dependencies.
`default_nettype none

package kdrb_pkg;

  // Default sizing
  localparam int KeyCountDefault    = 16;
  localparam int FilterDepthDefault = 4;

  // Register file
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS   = 3'd0,
    CFG_REPEAT_DELAY = 3'd1,
    CFG_ACCEL_STEP   = 3'd2,
    CFG_PAUSE        = 3'd3,
    CFG_DOUBLE_GAP   = 3'd4
  } cfg_index_t;

  localparam logic [7:0] LongPressReset   = 8'd24;
  localparam logic [7:0] RepeatDelayReset = 8'd40;
  localparam logic [7:0] AccelStepReset   = 8'd48;
  localparam logic [7:0] PauseReset       = 8'd64;
  localparam logic [7:0] DoubleGapReset   = 8'd16;

  // Releasing at period 16 below this count keeps the press count
  localparam logic [7:0] QuickReleaseTicks = 8'd16;

  // Item modes
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_PAUSE = 2'd1,
    MODE_KILL  = 2'd2
  } mode_t;

  // Per-key phase
  typedef enum logic [3:0] {
    PH_OFF    = 4'd0,
    PH_START  = 4'd1,
    PH_DELAY  = 4'd2,
    PH_PAUSE  = 4'd3,
    PH_KILLED = 4'd4,
    PH_RPT16  = 4'd5,
    PH_RPT8   = 4'd6,
    PH_RPT4   = 4'd7,
    PH_RPT2   = 4'd8,
    PH_RPT1   = 4'd9
  } key_phase_t;

  // Event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_FIRST   = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_kind_t;

  // Configuration snapshot handed to the update logic
  typedef struct packed {
    logic [7:0] long_press;
    logic [7:0] repeat_delay;
    logic [7:0] accel_step;
    logic [7:0] pause;
    logic [7:0] double_gap;
  } cfg_t;

  // Low-bit mask of the repeat period for a repeating phase
  function automatic logic [3:0] rpt_mask(input key_phase_t ph);
    logic [3:0] m;
    begin
      unique case (ph)
        PH_RPT16: m = 4'hF;
        PH_RPT8:  m = 4'h7;
        PH_RPT4:  m = 4'h3;
        PH_RPT2:  m = 4'h1;
        default:  m = 4'h0;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

@@ src/kdrb_state_mem.sv @@
// Per-key state memory: one write and one registered read port.
// Valid bits make unwritten entries read as zero; a write to the entry being
// read in the same cycle is forwarded. No package dependencies.
`default_nettype none

module kdrb_state_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int WIDTH  = 18
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] entry_vld_r;
  logic [WIDTH-1:0] raw_r;
  logic [WIDTH-1:0] fwd_data_r;
  logic             fwd_r;
  logic             raw_vld_r;
  logic             hit;
  logic             rd_in_range;

  assign hit         = wr_en && (wr_addr == rd_addr);
  assign rd_in_range = int'(rd_addr) < DEPTH;

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_r      <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Valid bits and read-side control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      fwd_r       <= 1'b0;
      raw_vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_r     <= hit;
        raw_vld_r <= rd_in_range && entry_vld_r[rd_addr];
      end
    end
  end

  // Forwarded data wins; an unwritten entry reads as zero
  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (raw_vld_r) begin
      rd_data = raw_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

@@ src/key_debounce_repeat_bank.sv @@
// Each item's state is read, updated and registered. Throughput: one item
// per cycle unless the output stalls, set by the single read-modify-write of
// the per-key state memory, with write-to-read forwarding for a repeated key.
// Reset: registers return to defaults and every key to off at once through
// per-entry valid bits; no clearing pass. Depends on kdrb_pkg, kdrb_state_mem.
`default_nettype none

module key_debounce_repeat_bank #(
  parameter int KEY_COUNT    = kdrb_pkg::KeyCountDefault,
  parameter int FILTER_DEPTH = kdrb_pkg::FilterDepthDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [kdrb_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [kdrb_pkg::CfgDataW-1:0] cfg_wdata,
  // items in
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [3:0]                    in_key_index,
  input  wire logic                          in_key_level,
  // results out
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_event_kind,
  output logic [3:0]                         out_event_key,
  output logic                               out_pressed,
  output logic [1:0]                         out_double_count
);

  localparam int ADDR_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int ENTRY_W = FILTER_DEPTH + 8 + 2 + 4;
  localparam logic [FILTER_DEPTH-1:0] HistFull = '1;

  // Configuration registers
  kdrb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press   <= kdrb_pkg::LongPressReset;
      cfg_r.repeat_delay <= kdrb_pkg::RepeatDelayReset;
      cfg_r.accel_step   <= kdrb_pkg::AccelStepReset;
      cfg_r.pause        <= kdrb_pkg::PauseReset;
      cfg_r.double_gap   <= kdrb_pkg::DoubleGapReset;
    end else if (cfg_wr_en) begin
      unique case (kdrb_pkg::cfg_index_t'(cfg_index))
        kdrb_pkg::CFG_LONG_PRESS:   cfg_r.long_press   <= cfg_wdata;
        kdrb_pkg::CFG_REPEAT_DELAY: cfg_r.repeat_delay <= cfg_wdata;
        kdrb_pkg::CFG_ACCEL_STEP:   cfg_r.accel_step   <= cfg_wdata;
        kdrb_pkg::CFG_PAUSE:        cfg_r.pause        <= cfg_wdata;
        kdrb_pkg::CFG_DOUBLE_GAP:   cfg_r.double_gap   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic             s1_valid_r;
  logic             s1_adv;
  logic             in_xfer;
  logic [1:0]       s1_mode_r;
  logic [3:0]       s1_key_r;
  logic             s1_level_r;
  logic             s1_in_range_r;
  logic             in_range;

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;
  assign in_range = int'(in_key_index) < KEY_COUNT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r     <= in_mode;
      s1_key_r      <= in_key_index;
      s1_level_r    <= in_key_level;
      s1_in_range_r <= in_range;
    end
  end

  // State memory
  logic [ENTRY_W-1:0] rd_entry;
  logic [ENTRY_W-1:0] wr_entry;
  logic               wr_en;

  assign wr_en = s1_adv && s1_in_range_r;

  kdrb_state_mem #(
    .DEPTH  (KEY_COUNT),
    .ADDR_W (ADDR_W),
    .WIDTH  (ENTRY_W)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (ADDR_W'(in_key_index)),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(s1_key_r)),
    .wr_data (wr_entry)
  );

  // Unpack the current entry
  logic [FILTER_DEPTH-1:0] cur_hist;
  logic [7:0]              cur_tick;
  logic [1:0]              cur_press;
  kdrb_pkg::key_phase_t    cur_phase;

  assign cur_hist  = rd_entry[ENTRY_W-1 -: FILTER_DEPTH];
  assign cur_tick  = rd_entry[13:6];
  assign cur_press = rd_entry[5:4];
  assign cur_phase = kdrb_pkg::key_phase_t'(rd_entry[3:0]);

  // Per-key update
  logic [FILTER_DEPTH:0]   hist_shift;
  logic [FILTER_DEPTH-1:0] nx_hist;
  logic [7:0]              nx_tick;
  logic [1:0]              nx_press;
  kdrb_pkg::key_phase_t    nx_phase;
  kdrb_pkg::event_kind_t   nx_event;

  assign hist_shift = {cur_hist, s1_level_r};

  always_comb begin
    nx_hist  = cur_hist;
    nx_tick  = cur_tick;
    nx_press = cur_press;
    nx_phase = cur_phase;
    nx_event = kdrb_pkg::EV_NONE;
    unique case (kdrb_pkg::mode_t'(s1_mode_r))
      kdrb_pkg::MODE_TICK: begin
        nx_hist = hist_shift[FILTER_DEPTH-1:0];
        nx_tick = cur_tick + 8'd1;
        // all-zero history ends a press
        if (nx_phase != kdrb_pkg::PH_OFF && nx_hist == '0) begin
          if (nx_phase != kdrb_pkg::PH_KILLED) begin
            nx_event = kdrb_pkg::EV_RELEASE;
            if (!(nx_phase == kdrb_pkg::PH_RPT16 &&
                  nx_tick < kdrb_pkg::QuickReleaseTicks)) begin
              nx_press = 2'd0;
            end
          end
          nx_tick  = 8'd0;
          nx_phase = kdrb_pkg::PH_OFF;
        end
        case (nx_phase)
          kdrb_pkg::PH_OFF: begin
            if (nx_hist == HistFull) begin
              nx_phase = kdrb_pkg::PH_START;
              if (nx_tick > cfg_r.double_gap) begin
                nx_press = 2'd0;
              end
              nx_tick = 8'd0;
            end
          end
          kdrb_pkg::PH_START: begin
            nx_event = kdrb_pkg::EV_FIRST;
            nx_press = nx_press + 2'd1;
            nx_phase = kdrb_pkg::PH_DELAY;
            nx_tick  = 8'd0;
          end
          kdrb_pkg::PH_DELAY: begin
            if (nx_tick == cfg_r.long_press) begin
              nx_event = kdrb_pkg::EV_LONG;
            end
            if (nx_tick == cfg_r.repeat_delay) begin
              nx_phase = kdrb_pkg::PH_RPT16;
              nx_tick  = 8'd0;
            end
          end
          kdrb_pkg::PH_PAUSE: begin
            if (nx_tick >= cfg_r.pause) begin
              nx_phase = kdrb_pkg::PH_RPT8;
              nx_tick  = 8'd0;
            end
          end
          kdrb_pkg::PH_RPT16, kdrb_pkg::PH_RPT8, kdrb_pkg::PH_RPT4,
          kdrb_pkg::PH_RPT2, kdrb_pkg::PH_RPT1: begin
            // period halves after each acceleration step
            if (nx_phase != kdrb_pkg::PH_RPT1 && nx_tick >= cfg_r.accel_step) begin
              nx_phase = kdrb_pkg::key_phase_t'(nx_phase + 4'd1);
              nx_tick  = 8'd0;
            end
            if ((nx_tick[3:0] & kdrb_pkg::rpt_mask(nx_phase)) == 4'd0) begin
              nx_event = kdrb_pkg::EV_REPEAT;
            end
          end
          default: ;  // killed or unused codes stay silent
        endcase
      end
      kdrb_pkg::MODE_PAUSE: begin
        nx_phase = kdrb_pkg::PH_PAUSE;
        nx_tick  = 8'd0;
      end
      kdrb_pkg::MODE_KILL: begin
        nx_phase = kdrb_pkg::PH_KILLED;
        nx_press = 2'd0;
      end
      default: ;  // unused mode leaves the key as is
    endcase
  end

  assign wr_entry = {nx_hist, nx_tick, nx_press, 4'(nx_phase)};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_key <= s1_key_r;
      if (s1_in_range_r) begin
        out_event_kind   <= 3'(nx_event);
        out_pressed      <= (nx_hist == HistFull);
        out_double_count <= nx_press;
      end else begin
        out_event_kind   <= 3'(kdrb_pkg::EV_NONE);
        out_pressed      <= 1'b0;
        out_double_count <= 2'd0;
      end
    end
  end

  // Checks
  a_out_key_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (int'(out_event_key) >= KEY_COUNT) |->
      out_event_kind == 3'(kdrb_pkg::EV_NONE) && out_double_count == 2'd0 && !out_pressed)
    else $error("out-of-range key produced an event or state");

  a_release_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == 3'(kdrb_pkg::EV_RELEASE) |-> !out_pressed)
    else $error("release reported while still pressed");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_key_r) && $stable(s1_mode_r))
    else $error("stalled item lost from the update stage");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind <= 3'(kdrb_pkg::EV_RELEASE))
    else $error("undefined event code");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> s1_valid_r && s1_in_range_r && (!out_valid || out_ready))
    else $error("state written without a result transfer slot");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for key_debounce_repeat_bank: directed and random key traffic,
// with every result compared against an in-bench model of the per-key qualifiers.
// Depends on kdrb_pkg and the key_debounce_repeat_bank RTL.

module tb_top;
  import kdrb_pkg::*;

  localparam int         KeyCount     = KeyCountDefault;
  localparam logic [1:0] ModeUnused   = 2'd3;
  localparam logic [3:0] HistPressed  = '1;
  localparam logic [3:0] HistReleased = '0;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] key;
    logic       pressed;
    logic [1:0] presses;
  } key_report_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_mode;
  logic [3:0] in_key_index;
  logic       in_key_level;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_event_kind;
  logic [3:0] out_event_key;
  logic       out_pressed;
  logic [1:0] out_double_count;

  key_debounce_repeat_bank i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_key_index     (in_key_index),
    .in_key_level     (in_key_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_event_key    (out_event_key),
    .out_pressed      (out_pressed),
    .out_double_count (out_double_count)
  );

  // Key bank model state
  logic [3:0]  level_hist [KeyCount];
  logic [7:0]  tick_cnt   [KeyCount];
  logic [1:0]  press_cnt  [KeyCount];
  key_phase_t  phase_of   [KeyCount];
  cfg_t        model_cfg;
  key_report_t expected_reports [$];

  // Stimulus plan per key: level being held and ticks left to hold it
  bit          plan_level [KeyCount];
  int          plan_left  [KeyCount];

  int sender_idle_pct;
  int receiver_idle_pct;
  int stall_request;
  int hold_off_left;
  int error_count;
  int items_sent;
  int results_checked;
  int input_stall_cycles;
  int events_seen [5];

  key_report_t got_report;
  key_report_t want_report;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Advance the model by one item and queue the result it predicts
  task automatic predict_key_item(input logic [1:0] mode, input logic [3:0] k,
                                  input logic lvl);
    event_kind_t ev;
    logic [3:0]  mask;
    key_report_t rep;
    ev = EV_NONE;
    case (mode)
      MODE_TICK: begin
        level_hist[k] = {level_hist[k][2:0], lvl};
        tick_cnt[k]   = tick_cnt[k] + 8'd1;
        // all-zero history ends any press; a killed key drops out silently
        if (phase_of[k] != PH_OFF && level_hist[k] == HistReleased) begin
          if (phase_of[k] != PH_KILLED) begin
            ev = EV_RELEASE;
            if (!(phase_of[k] == PH_RPT16 && tick_cnt[k] < QuickReleaseTicks))
              press_cnt[k] = '0;
          end
          tick_cnt[k] = '0;
          phase_of[k] = PH_OFF;
        end
        case (phase_of[k])
          PH_OFF: begin
            if (level_hist[k] == HistPressed) begin
              phase_of[k] = PH_START;
              if (tick_cnt[k] > model_cfg.double_gap) press_cnt[k] = '0;
              tick_cnt[k] = '0;
            end
          end
          PH_START: begin
            ev           = EV_FIRST;
            press_cnt[k] = press_cnt[k] + 2'd1;
            phase_of[k]  = PH_DELAY;
            tick_cnt[k]  = '0;
          end
          PH_DELAY: begin
            if (tick_cnt[k] == model_cfg.long_press) ev = EV_LONG;
            if (tick_cnt[k] == model_cfg.repeat_delay) begin
              phase_of[k] = PH_RPT16;
              tick_cnt[k] = '0;
            end
          end
          PH_PAUSE: begin
            if (tick_cnt[k] >= model_cfg.pause) begin
              phase_of[k] = PH_RPT8;
              tick_cnt[k] = '0;
            end
          end
          PH_RPT16, PH_RPT8, PH_RPT4, PH_RPT2, PH_RPT1: begin
            // speed up one step, then repeat when the count hits the period
            if (phase_of[k] != PH_RPT1 && tick_cnt[k] >= model_cfg.accel_step) begin
              phase_of[k] = key_phase_t'(phase_of[k] + 1);
              tick_cnt[k] = '0;
            end
            mask = 4'hF >> (phase_of[k] - PH_RPT16);
            if ((tick_cnt[k][3:0] & mask) == '0) ev = EV_REPEAT;
          end
          default: ;
        endcase
      end
      MODE_PAUSE: begin
        phase_of[k] = PH_PAUSE;
        tick_cnt[k] = '0;
      end
      MODE_KILL: begin
        phase_of[k]  = PH_KILLED;
        press_cnt[k] = '0;
      end
      default: ;
    endcase
    rep = '{kind: ev, key: k, pressed: (level_hist[k] == HistPressed),
            presses: press_cnt[k]};
    expected_reports.push_back(rep);
  endtask

  // Offer one item, idling first at random, and model it on transfer
  task automatic send_item(input logic [1:0] mode, input logic [3:0] k, input logic lvl);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_key_index <= k;
    in_key_level <= lvl;
    do @(posedge clk); while (!in_ready);
    predict_key_item(mode, k, lvl);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Let every outstanding result drain, plus the block's latency
  task automatic wait_idle();
    stop_sending();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // All five registers, back to back, while the block is idle
  task automatic apply_settings(input cfg_t s);
    wait_idle();
    write_reg(CFG_LONG_PRESS, s.long_press);
    write_reg(CFG_REPEAT_DELAY, s.repeat_delay);
    write_reg(CFG_ACCEL_STEP, s.accel_step);
    write_reg(CFG_PAUSE, s.pause);
    write_reg(CFG_DOUBLE_GAP, s.double_gap);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_cfg = s;
  endtask

  // Held presses and gaps with bounce on a few keys, plus stray items
  task automatic press_traffic(input int n_items, input int n_keys, input int max_hold,
                               input int max_gap);
    logic [3:0] first_key;
    logic [3:0] k;
    logic       lvl;
    int         r;
    first_key = 4'($urandom_range(15));
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(199);
      k = first_key + 4'($urandom_range(n_keys - 1));
      if (r < 6) begin
        send_item(2'($urandom_range(3)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      end else if (r < 9) begin
        send_item((r == 8) ? MODE_KILL : MODE_PAUSE, k, 1'($urandom_range(1)));
      end else begin
        if (plan_left[k] == 0) begin
          plan_level[k] = !plan_level[k];
          plan_left[k]  = plan_level[k] ? $urandom_range(max_hold, 4)
                                        : $urandom_range(max_gap, 1);
        end
        plan_left[k]--;
        lvl = plan_level[k] ^ ($urandom_range(39) == 0);
        send_item(MODE_TICK, k, lvl);
      end
    end
  endtask

  // Reset timings: press, pause, kill, release, unused mode
  task automatic test_directed_events();
    repeat (4) send_item(MODE_TICK, 4'd0, 1'b1);
    send_item(MODE_TICK, 4'd0, 1'b1);
    send_item(MODE_PAUSE, 4'd0, 1'b0);
    send_item(MODE_TICK, 4'd0, 1'b1);
    send_item(MODE_KILL, 4'd0, 1'b1);
    // a killed key goes back to off without a release
    repeat (4) send_item(MODE_TICK, 4'd0, 1'b0);
    repeat (5) send_item(MODE_TICK, 4'd0, 1'b1);
    repeat (4) send_item(MODE_TICK, 4'd0, 1'b0);
    send_item(ModeUnused, 4'd15, 1'b1);
    // pausing a released key gives a release on the next tick
    send_item(MODE_PAUSE, 4'd15, 1'b1);
    send_item(MODE_TICK, 4'd15, 1'b0);
    send_item(MODE_KILL, 4'd15, 1'b0);
  endtask

  task automatic test_short_timings();
    apply_settings('{long_press: 8'd1, repeat_delay: 8'd1, accel_step: 8'd1,
                     pause: 8'd1, double_gap: 8'd0});
    press_traffic(200, 2, 60, 8);
  endtask

  task automatic test_mid_timings();
    cfg_t s;
    s.long_press   = 8'($urandom_range(16, 1));
    s.repeat_delay = 8'($urandom_range(16, 1));
    s.accel_step   = 8'($urandom_range(16, 1));
    s.pause        = 8'($urandom_range(16, 1));
    s.double_gap   = 8'($urandom_range(24, 0));
    apply_settings(s);
    press_traffic(180, 3, 90, 30);
  endtask

  task automatic test_long_timings();
    apply_settings('{long_press: 8'd255, repeat_delay: 8'd255, accel_step: 8'd255,
                     pause: 8'd255, double_gap: 8'd255});
    press_traffic(250, 1, 320, 300);
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_input_stall();
    apply_settings('{long_press: LongPressReset, repeat_delay: RepeatDelayReset,
                     accel_step: AccelStepReset, pause: PauseReset,
                     double_gap: DoubleGapReset});
    stall_request = 100;
    press_traffic(60, 4, 40, 10);
  endtask

  task automatic test_default_timings();
    press_traffic(150, 4, 200, 24);
  endtask

  // Receiver: random idling, or a counted hold-off when requested
  always @(negedge clk) begin
    if (stall_request != 0) begin
      hold_off_left = stall_request;
      stall_request = 0;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic report_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    error_count++;
  endtask

  // Result checker: each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_ready) input_stall_cycles++;
      if (out_valid && out_ready) begin
        got_report = '{kind: out_event_kind, key: out_event_key, pressed: out_pressed,
                       presses: out_double_count};
        if (expected_reports.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, actual %h",
                   $time, got_report);
          error_count++;
        end else begin
          want_report = expected_reports.pop_front();
          if (got_report.kind !== want_report.kind)
            report_mismatch("event_kind", 8'(want_report.kind), 8'(got_report.kind));
          if (got_report.key !== want_report.key)
            report_mismatch("event_key", 8'(want_report.key), 8'(got_report.key));
          if (got_report.pressed !== want_report.pressed)
            report_mismatch("pressed", 8'(want_report.pressed), 8'(got_report.pressed));
          if (got_report.presses !== want_report.presses)
            report_mismatch("double_count", 8'(want_report.presses),
                            8'(got_report.presses));
          events_seen[want_report.kind]++;
          results_checked++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_LONG_PRESS;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_mode       = MODE_TICK;
    in_key_index  = '0;
    in_key_level  = 1'b0;
    out_ready     = 1'b0;
    stall_request = 0;
    hold_off_left = 0;
    for (int k = 0; k < KeyCount; k++) begin
      level_hist[k] = '0;
      tick_cnt[k]   = '0;
      press_cnt[k]  = '0;
      phase_of[k]   = PH_OFF;
      plan_level[k] = 1'b0;
      plan_left[k]  = 0;
    end
    model_cfg = '{long_press: LongPressReset, repeat_delay: RepeatDelayReset,
                  accel_step: AccelStepReset, pause: PauseReset,
                  double_gap: DoubleGapReset};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct   = 13;
    receiver_idle_pct = 82;
    test_directed_events();
    test_short_timings();
    sender_idle_pct   = 82;
    receiver_idle_pct = 13;
    test_mid_timings();
    test_long_timings();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_input_stall();
    test_default_timings();

    stop_sending();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d items, %0d results checked, over six timing and traffic phases.",
             items_sent, results_checked);
    $display("Events: %0d first, %0d long, %0d repeat, %0d release; %0d input stall cycles.",
             events_seen[EV_FIRST], events_seen[EV_LONG], events_seen[EV_REPEAT],
             events_seen[EV_RELEASE], input_stall_cycles);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/kdrb_pkg.sv
src/kdrb_state_mem.sv
src/key_debounce_repeat_bank.sv
tb/tb_top.sv
